[hdl/ihrc_pkg.sv]
// Package for the Intel HEX record checker: record phases, result kinds,
// error codes and the character decode helpers. Depends on nothing.

package ihrc_pkg;

    // Reset values of the address window registers
    localparam logic [15:0] LowestAddrReset  = 16'hF800;
    localparam logic [15:0] HighestAddrReset = 16'hFFFF;

    // Configuration register indexes
    localparam logic [1:0] CfgLowestAddr  = 2'd0;
    localparam logic [1:0] CfgHighestAddr = 2'd1;

    localparam logic [7:0] CharColon = 8'h3A;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_COUNT,
        PH_ADDR,
        PH_TYPE,
        PH_DATA,
        PH_CKSUM,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_END   = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TRUNCATED = 3'd1,
        ERR_BAD_COUNT = 3'd2,
        ERR_BAD_TYPE  = 3'd3,
        ERR_RANGE     = 3'd4,
        ERR_CHECKSUM  = 3'd5
    } err_t;

    // True for 0-9, A-F and a-f.
    function automatic logic hex_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    // Nibble value of a character; non-hex characters decode without check.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c <= 8'h46) begin
            v = c - 8'h41 + 8'd10;
        end else begin
            v = c - 8'h61 + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

[hdl/intel_hex_record_checker.sv]
// Top level of the Intel HEX record checker: character decode, record state
// and the result register. Depends on ihrc_pkg.

// The block takes one file character per clock on the s_ channel and gives at
// most one result per character on the m_ channel: each data byte with its
// address, a verdict at the end of every record, or one error. A character is
// fully decoded in the cycle it is accepted and its result, if any, is valid on
// the m_ channel from the next cycle, so with m_tready high the sustained rate
// is one character per cycle. The single result register lets a new character
// enter in the same cycle the previous result is taken, and s_tready only drops
// while a waiting result is stalled by m_tready. After an end record or an
// error the block discards all characters until reset. The address window
// registers should be written only while no record is in progress.
module intel_hex_record_checker (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Character stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // last_char
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] byte_value, [23:8] byte_address,
                                   // [26:24] error_code, [31:27] zero
    output logic [1:0]  m_tuser    // [1:0] kind
);

    logic [15:0] lowest_reg, highest_reg;

    ihrc_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  dpos_reg, dpos_next;
    logic [3:0]  hnib_reg, hnib_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] addr_reg, addr_next;
    logic        is_end_reg, is_end_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  idx_reg, idx_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg, out_kind_next;
    logic [7:0]  out_value_reg, out_value_next;
    logic [15:0] out_addr_reg, out_addr_next;
    logic [2:0]  out_err_reg, out_err_next;

    logic        s_accept;
    logic [3:0]  nib;
    logic [7:0]  byte_val;
    logic [7:0]  sum_add;
    logic [2:0]  dpos_inc;
    logic [7:0]  idx_inc;
    logic        res_valid;
    ihrc_pkg::kind_t res_kind;
    logic [7:0]  res_value;
    logic [15:0] res_addr;
    ihrc_pkg::err_t res_err;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign nib      = ihrc_pkg::nibble_of(s_tdata);
    assign byte_val = {hnib_reg, nib};
    assign sum_add  = sum_reg + byte_val;
    assign dpos_inc = dpos_reg + 3'd1;
    assign idx_inc  = idx_reg + 8'd1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lowest_reg  <= ihrc_pkg::LowestAddrReset;
            highest_reg <= ihrc_pkg::HighestAddrReset;
        end else if (cfg_we) begin
            if (cfg_index == ihrc_pkg::CfgLowestAddr) begin
                lowest_reg <= cfg_data;
            end else if (cfg_index == ihrc_pkg::CfgHighestAddr) begin
                highest_reg <= cfg_data;
            end
        end
    end

    // Per-character decode: next record state and the optional result
    always_comb begin
        phase_next  = phase_reg;
        dpos_next   = dpos_reg;
        hnib_next   = hnib_reg;
        len_next    = len_reg;
        addr_next   = addr_reg;
        is_end_next = is_end_reg;
        sum_next    = sum_reg;
        idx_next    = idx_reg;
        res_valid   = 1'b0;
        res_kind    = ihrc_pkg::KIND_ERROR;
        res_value   = 8'd0;
        res_addr    = 16'd0;
        res_err     = ihrc_pkg::ERR_NONE;

        if (phase_reg == ihrc_pkg::PH_WAIT) begin
            if (s_tlast) begin
                // File ended without an end record
                phase_next = ihrc_pkg::PH_DONE;
                res_valid  = 1'b1;
                res_err    = ihrc_pkg::ERR_TRUNCATED;
            end else if (s_tdata == ihrc_pkg::CharColon) begin
                phase_next = ihrc_pkg::PH_COUNT;
                dpos_next  = 3'd0;
                hnib_next  = 4'd0;
                len_next   = 8'd0;
                addr_next  = 16'd0;
                is_end_next = 1'b0;
                sum_next   = 8'd0;
                idx_next   = 8'd0;
            end
        end else if (phase_reg != ihrc_pkg::PH_DONE) begin
            if (phase_reg == ihrc_pkg::PH_COUNT && !ihrc_pkg::hex_digit(s_tdata)) begin
                phase_next = ihrc_pkg::PH_DONE;
                res_valid  = 1'b1;
                res_err    = ihrc_pkg::ERR_BAD_COUNT;
            end else if (s_tlast) begin
                phase_next = ihrc_pkg::PH_DONE;
                res_valid  = 1'b1;
                res_err    = ihrc_pkg::ERR_TRUNCATED;
            end else if (!dpos_reg[0]) begin
                // First digit of a byte
                hnib_next = nib;
                dpos_next = dpos_inc;
            end else begin
                // Second digit completes a byte
                dpos_next = dpos_inc;
                sum_next  = sum_add;
                unique case (phase_reg)
                    ihrc_pkg::PH_COUNT: begin
                        len_next   = byte_val;
                        dpos_next  = 3'd0;
                        phase_next = ihrc_pkg::PH_ADDR;
                    end
                    ihrc_pkg::PH_ADDR: begin
                        addr_next = {addr_reg[7:0], byte_val};
                        if (dpos_inc == 3'd4) begin
                            dpos_next  = 3'd0;
                            phase_next = ihrc_pkg::PH_TYPE;
                        end
                    end
                    ihrc_pkg::PH_TYPE: begin
                        is_end_next = byte_val[0];
                        dpos_next   = 3'd0;
                        if (byte_val > 8'd1) begin
                            phase_next = ihrc_pkg::PH_DONE;
                            res_valid  = 1'b1;
                            res_err    = ihrc_pkg::ERR_BAD_TYPE;
                        end else if (!byte_val[0] &&
                                     (addr_reg < lowest_reg || addr_reg > highest_reg)) begin
                            phase_next = ihrc_pkg::PH_DONE;
                            res_valid  = 1'b1;
                            res_err    = ihrc_pkg::ERR_RANGE;
                        end else begin
                            idx_next   = 8'd0;
                            phase_next = (len_reg != 8'd0) ? ihrc_pkg::PH_DATA
                                                           : ihrc_pkg::PH_CKSUM;
                        end
                    end
                    ihrc_pkg::PH_DATA: begin
                        dpos_next = 3'd0;
                        if (!is_end_reg) begin
                            res_valid = 1'b1;
                            res_kind  = ihrc_pkg::KIND_BYTE;
                            res_value = byte_val;
                            res_addr  = addr_reg + {8'd0, idx_reg};
                        end
                        idx_next = idx_inc;
                        if (idx_inc == len_reg) begin
                            phase_next = ihrc_pkg::PH_CKSUM;
                        end
                    end
                    ihrc_pkg::PH_CKSUM: begin
                        dpos_next = 3'd0;
                        res_valid = 1'b1;
                        if (sum_add != 8'd0) begin
                            phase_next = ihrc_pkg::PH_DONE;
                            res_err    = ihrc_pkg::ERR_CHECKSUM;
                        end else if (!is_end_reg) begin
                            phase_next = ihrc_pkg::PH_WAIT;
                            res_kind   = ihrc_pkg::KIND_DATA;
                            res_addr   = addr_reg;
                        end else begin
                            phase_next = ihrc_pkg::PH_DONE;
                            res_kind   = ihrc_pkg::KIND_END;
                            res_addr   = addr_reg;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // Result register: loaded on each accepted character, cleared when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        out_addr_next  = out_addr_reg;
        out_err_next   = out_err_reg;
        if (s_accept) begin
            out_valid_next = res_valid;
            out_kind_next  = res_kind;
            out_value_next = res_value;
            out_addr_next  = res_addr;
            out_err_next   = res_err;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= ihrc_pkg::PH_WAIT;
            dpos_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (s_accept) begin
                phase_reg <= phase_next;
                dpos_reg  <= dpos_next;
            end
        end
    end

    // Record payload state, initialized at every colon, and the result register data
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            hnib_reg   <= hnib_next;
            len_reg    <= len_next;
            addr_reg   <= addr_next;
            is_end_reg <= is_end_next;
            sum_reg    <= sum_next;
            idx_reg    <= idx_next;
        end
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
        out_addr_reg  <= out_addr_next;
        out_err_reg   <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_err_reg, out_addr_reg, out_value_reg};
    assign m_tuser  = out_kind_reg;

endmodule

[verif/intel_hex_record_checker_test.sv]
// Testbench for intel_hex_record_checker: streams Intel HEX text into the block
// and checks every byte, record verdict and error against its own record decoder.
// Depends on ihrc_pkg and the intel_hex_record_checker RTL.
`timescale 1ns / 100ps

module intel_hex_record_checker_test;

    localparam int CycleLimit = 200000;
    localparam int RandomCharBudget = 500;
    localparam int LongRecordAfter = 280;
    localparam logic [7:0] LongRecordLen = 8'd100;

    // Register indexes past the two address registers; writes there are dropped.
    localparam logic [1:0] CfgSpareA = 2'd2;
    localparam logic [1:0] CfgSpareB = 2'd3;

    // Record types the block accepts
    localparam logic [7:0] RecData = 8'h00;
    localparam logic [7:0] RecEnd  = 8'h01;

    // How a digit is spelled in the text
    localparam int StyleUpper = 0;
    localparam int StyleLower = 1;
    localparam int StyleWild  = 2;

    typedef struct packed {
        ihrc_pkg::kind_t kind;
        logic [7:0]      value;
        logic [15:0]     addr;
        ihrc_pkg::err_t  err;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    // Record decoder state, mirrored from the block's behavior
    ihrc_pkg::phase_t rec_phase = ihrc_pkg::PH_WAIT;
    logic [2:0]  nib_count = '0;
    logic [3:0]  upper_nib = '0;
    logic [7:0]  rec_len = '0;
    logic [15:0] rec_addr = '0;
    logic [7:0]  rec_type = '0;
    logic [7:0]  rec_sum = '0;
    logic [7:0]  byte_idx = '0;
    logic [15:0] win_lo = ihrc_pkg::LowestAddrReset;
    logic [15:0] win_hi = ihrc_pkg::HighestAddrReset;

    result_t pending_results[$];
    int      failures = 0;
    int      cycle_count = 0;
    int      chars_accepted = 0;
    int      burst_left = 0;
    bit      idling = 1'b1;

    intel_hex_record_checker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Character classification and decode; non-hex characters fall into the
    // nearest range and keep only the low four bits.
    function automatic bit is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
               (c >= "a" && c <= "f");
    endfunction

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [7:0] base;
        logic [7:0] v;
        if (c <= "9") begin
            base = "0";
        end else if (c <= "F") begin
            base = "A" - 8'd10;
        end else begin
            base = "a" - 8'd10;
        end
        v = c - base;
        return v[3:0];
    endfunction

    task automatic queue_result(input ihrc_pkg::kind_t k, input logic [7:0] v,
                                input logic [15:0] a, input ihrc_pkg::err_t e);
        result_t r;
        r.kind = k;
        r.value = v;
        r.addr = a;
        r.err = e;
        pending_results.push_back(r);
    endtask

    // Any error ends the file: the block stays silent until reset.
    task automatic abandon_file(input ihrc_pkg::err_t e);
        rec_phase = ihrc_pkg::PH_DONE;
        queue_result(ihrc_pkg::KIND_ERROR, 8'h00, 16'h0000, e);
    endtask

    // Advances the record decoder by one accepted character request and queues
    // the result it causes, if any.
    task automatic decode_record_char(input logic [7:0] c, input logic last);
        logic [7:0] b;
        b = {upper_nib, digit_value(c)};
        if (rec_phase == ihrc_pkg::PH_WAIT) begin
            if (last) begin
                abandon_file(ihrc_pkg::ERR_TRUNCATED);
            end else if (c == ihrc_pkg::CharColon) begin
                rec_phase = ihrc_pkg::PH_COUNT;
                nib_count = '0;
                upper_nib = '0;
                rec_len = '0;
                rec_addr = '0;
                rec_type = '0;
                rec_sum = '0;
                byte_idx = '0;
            end
        end else if (rec_phase != ihrc_pkg::PH_DONE) begin
            // A bad count digit wins over the end of the file on that character.
            if (rec_phase == ihrc_pkg::PH_COUNT && !is_hex(c)) begin
                abandon_file(ihrc_pkg::ERR_BAD_COUNT);
            end else if (last) begin
                abandon_file(ihrc_pkg::ERR_TRUNCATED);
            end else if (!nib_count[0]) begin
                upper_nib = digit_value(c);
                nib_count++;
            end else begin
                nib_count++;
                rec_sum += b;
                case (rec_phase)
                    ihrc_pkg::PH_COUNT: begin
                        rec_len = b;
                        nib_count = '0;
                        rec_phase = ihrc_pkg::PH_ADDR;
                    end
                    ihrc_pkg::PH_ADDR: begin
                        rec_addr = {rec_addr[7:0], b};
                        if (nib_count == 3'd4) begin
                            nib_count = '0;
                            rec_phase = ihrc_pkg::PH_TYPE;
                        end
                    end
                    ihrc_pkg::PH_TYPE: begin
                        rec_type = b;
                        nib_count = '0;
                        if (b > RecEnd) begin
                            abandon_file(ihrc_pkg::ERR_BAD_TYPE);
                        end else if (b == RecData &&
                                     (rec_addr < win_lo || rec_addr > win_hi)) begin
                            abandon_file(ihrc_pkg::ERR_RANGE);
                        end else begin
                            byte_idx = '0;
                            rec_phase = (rec_len != 0) ? ihrc_pkg::PH_DATA
                                                       : ihrc_pkg::PH_CKSUM;
                        end
                    end
                    ihrc_pkg::PH_DATA: begin
                        nib_count = '0;
                        // End records sum their data but report no bytes.
                        if (rec_type == RecData) begin
                            queue_result(ihrc_pkg::KIND_BYTE, b,
                                         rec_addr + {8'h00, byte_idx}, ihrc_pkg::ERR_NONE);
                        end
                        byte_idx++;
                        if (byte_idx == rec_len) begin
                            rec_phase = ihrc_pkg::PH_CKSUM;
                        end
                    end
                    default: begin
                        nib_count = '0;
                        if (rec_sum != 0) begin
                            abandon_file(ihrc_pkg::ERR_CHECKSUM);
                        end else if (rec_type == RecData) begin
                            rec_phase = ihrc_pkg::PH_WAIT;
                            queue_result(ihrc_pkg::KIND_DATA, 8'h00, rec_addr,
                                         ihrc_pkg::ERR_NONE);
                        end else begin
                            rec_phase = ihrc_pkg::PH_DONE;
                            queue_result(ihrc_pkg::KIND_END, 8'h00, rec_addr,
                                         ihrc_pkg::ERR_NONE);
                        end
                    end
                endcase
            end
        end
    endtask

    // Compares one result with the oldest pending one.
    task automatic check_result();
        result_t got;
        result_t want;
        got.kind = ihrc_pkg::kind_t'(m_tuser);
        got.value = m_tdata[7:0];
        got.addr = m_tdata[23:8];
        got.err = ihrc_pkg::err_t'(m_tdata[26:24]);
        if (pending_results.size() == 0) begin
            $display("%0t: expected no result, got kind %0d byte %h address %h error %0d",
                     $time, got.kind, got.value, got.addr, got.err);
            failures++;
        end else begin
            want = pending_results.pop_front();
            if (got !== want || m_tdata[31:27] !== 5'd0) begin
                $display("%0t: expected kind %0d byte %h address %h error %0d,", $time,
                         want.kind, want.value, want.addr, want.err,
                         " got kind %0d byte %h address %h error %0d pad %h",
                         got.kind, got.value, got.addr, got.err, m_tdata[31:27]);
                failures++;
            end
        end
    endtask

    // Result side: check each taken result, stall on a pattern that steps through
    // four modes, and stop the run at the cycle limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("FAIL");
            $finish;
        end else begin
            if (aresetn && m_tvalid && m_tready) begin
                check_result();
            end
            case ((cycle_count / 80) % 4)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (cycle_count % 7 != 0);
            endcase
        end
    end

    // Sends one character request, waits until it is taken, then maybe opens
    // a gap before the next burst.
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        decode_record_char(c, last);
        chars_accepted++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            if (idling) begin
                gap = $urandom_range(1, 5);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Stops the stream and lets every pending result drain.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge aclk);
        if (idx == ihrc_pkg::CfgLowestAddr) begin
            win_lo = d;
        end else if (idx == ihrc_pkg::CfgHighestAddr) begin
            win_hi = d;
        end
    endtask

    // Writes both window limits, sometimes with a stray write to a spare index.
    task automatic set_window(input logic [15:0] lo, input logic [15:0] hi);
        cfg_write(ihrc_pkg::CfgLowestAddr, lo);
        cfg_write(ihrc_pkg::CfgHighestAddr, hi);
        if ($urandom_range(0, 1)) begin
            cfg_write($urandom_range(0, 1) ? CfgSpareA : CfgSpareB,
                      16'($urandom_range(0, 16'hFFFF)));
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char(input logic [3:0] nib, input int style);
        logic [7:0] c;
        if (style == StyleWild) begin
            c = 8'($urandom_range(0, 255));
            while (digit_value(c) != nib) c = 8'($urandom_range(0, 255));
        end else if (nib < 4'd10) begin
            c = "0" + nib;
        end else begin
            c = ((style == StyleLower) ? "a" : "A") + nib - 8'd10;
        end
        return c;
    endfunction

    // Count digits are checked by the block, so they always stay real hex.
    function automatic int choose_style(input bit mixed, input bit count_digit);
        int r;
        r = $urandom_range(0, 4);
        if (!mixed || r < 3) begin
            return StyleUpper;
        end else if (r == 3 || count_digit) begin
            return StyleLower;
        end
        return StyleWild;
    endfunction

    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == ihrc_pkg::CharColon);
        return c;
    endfunction

    function automatic logic [7:0] pick_len();
        return ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 4))
                                          : 8'($urandom_range(5, 16));
    endfunction

    function automatic logic [15:0] window_addr();
        case ($urandom_range(0, 3))
            0: return win_lo;
            1: return win_hi;
            default: return 16'($urandom_range(win_lo, win_hi));
        endcase
    endfunction

    task automatic send_noise(input int n);
        repeat (n) send_char(noise_char(), 1'b0);
    endtask

    // Sends one record with random data. A nonzero sum_skew spoils the
    // checksum; cut is the text position that carries the end-of-file flag.
    task automatic send_record(input logic [7:0] len, input logic [15:0] addr,
                               input logic [7:0] rtype, input logic [7:0] sum_skew,
                               input int cut, input bit mixed);
        logic [7:0] fields[$];
        logic [7:0] text[$];
        logic [7:0] total;
        fields.push_back(len);
        fields.push_back(addr[15:8]);
        fields.push_back(addr[7:0]);
        fields.push_back(rtype);
        repeat (len) fields.push_back(8'($urandom_range(0, 255)));
        total = '0;
        foreach (fields[i]) total += fields[i];
        fields.push_back(8'h00 - total + sum_skew);
        foreach (fields[i]) begin
            text.push_back(pick_char(fields[i][7:4], choose_style(mixed, i == 0)));
            text.push_back(pick_char(fields[i][3:0], choose_style(mixed, i == 0)));
        end
        send_char(ihrc_pkg::CharColon, 1'b0);
        for (int i = 0; i < text.size(); i++) begin
            send_char(text[i], i == cut);
            if (i == cut) break;
        end
    endtask

    task automatic send_data_in_window(input logic [7:0] len);
        send_noise($urandom_range(0, 2));
        send_record(len, window_addr(), RecData, 8'h00, -1, 1'b1);
    endtask

    // Skipped extremes of the character range, then records on both edges of
    // the reset window, the upper one wrapping its byte address.
    task automatic test_directed();
        idling = 1'b1;
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h0D, 1'b0);
        send_char(8'h0A, 1'b0);
        send_record(8'd0, ihrc_pkg::LowestAddrReset, RecData, 8'h00, -1, 1'b0);
        send_record(8'd2, ihrc_pkg::HighestAddrReset, RecData, 8'h00, -1, 1'b1);
    endtask

    // Full, single-address, empty and random windows, with records on the edges.
    task automatic test_address_windows();
        logic [15:0] lo;
        for (int k = 0; k < 6; k++) begin
            wait_idle();
            lo = 16'($urandom_range(0, 16'hFFFF));
            case (k)
                0: set_window(16'h0000, 16'hFFFF);
                1: set_window(16'h0000, 16'h0000);
                2: set_window(16'hFFFF, 16'hFFFF);
                3: set_window(lo, lo);
                4: set_window(16'h8000, 16'h7FFF);
                default: set_window(lo, 16'($urandom_range(lo, 16'hFFFF)));
            endcase
            if (win_lo <= win_hi) begin
                repeat (2) send_data_in_window(pick_len());
            end else begin
                send_noise(3);
            end
        end
    endtask

    // Well-formed data records with random content, windows and pacing, plus
    // one long record.
    task automatic test_random_records();
        logic [15:0] lo;
        bit          long_sent;
        long_sent = 1'b0;
        while (chars_accepted < RandomCharBudget) begin
            if ($urandom_range(0, 7) == 0) begin
                wait_idle();
                lo = 16'($urandom_range(0, 16'hFFFF));
                set_window(lo, 16'($urandom_range(lo, 16'hFFFF)));
            end
            idling = ($urandom_range(0, 3) != 0);
            if (!long_sent && chars_accepted >= LongRecordAfter) begin
                long_sent = 1'b1;
                send_data_in_window(LongRecordLen);
            end else begin
                send_data_in_window(pick_len());
            end
        end
        idling = 1'b1;
    endtask

    // The file ends one way per run: a clean end record (with or without data)
    // or one of the errors. Whatever follows must be ignored.
    task automatic test_file_end();
        int unsigned ending;
        int          cut;
        logic [7:0]  len;
        logic [7:0]  c;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] a;
        wait_idle();
        ending = $urandom_range(0, 7);
        len = 8'($urandom_range(0, 4));
        case (ending)
            0: send_record(8'd0, 16'($urandom_range(0, 16'hFFFF)), RecEnd, 8'h00, -1, 1'b1);
            1: send_record(8'($urandom_range(1, 4)), 16'($urandom_range(0, 16'hFFFF)), RecEnd,
                           8'h00, -1, 1'b1);
            2: begin
                // Truncated inside a record, often on the final checksum digit.
                cut = $urandom_range(0, 1) ? 9 + 2 * len : $urandom_range(0, 9 + 2 * len);
                send_record(len, window_addr(), $urandom_range(0, 1) ? RecData : RecEnd, 8'h00,
                            cut, 1'b1);
            end
            3: begin
                // File ends while looking for the next record.
                send_noise($urandom_range(0, 3));
                send_char($urandom_range(0, 1) ? ihrc_pkg::CharColon : noise_char(), 1'b1);
            end
            4: begin
                send_char(ihrc_pkg::CharColon, 1'b0);
                if ($urandom_range(0, 1)) begin
                    send_char(pick_char(4'($urandom_range(0, 15)), StyleUpper), 1'b0);
                end
                do c = 8'($urandom_range(0, 255)); while (is_hex(c));
                send_char(c, 1'($urandom_range(0, 1)));
            end
            5: send_record(len, 16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(2, 255)),
                           8'h00, -1, 1'b1);
            6: begin
                // Data record outside a narrowed window, just above it or anywhere below it.
                lo = 16'($urandom_range(1, 16'hFFFF));
                hi = 16'($urandom_range(lo, 16'hFFFF));
                set_window(lo, hi);
                if (hi != 16'hFFFF && $urandom_range(0, 1)) begin
                    a = hi + 16'd1;
                end else begin
                    a = 16'($urandom_range(0, lo - 16'd1));
                end
                send_record(len, a, RecData, 8'h00, -1, 1'b1);
            end
            default: send_record(len, window_addr(), $urandom_range(0, 1) ? RecData : RecEnd,
                                 8'($urandom_range(1, 255)), -1, 1'b1);
        endcase
        send_noise(2);
        send_record(8'd1, window_addr(), RecData, 8'h00, -1, 1'b0);
        send_char(ihrc_pkg::CharColon, 1'b1);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_address_windows();
        test_random_records();
        test_file_end();
        wait_idle();
        repeat (8) @(posedge aclk);
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
